/* hw/rtl/pst_pkg.sv */
package pst_pkg;

  // Width and reset value of the active slot count register
  localparam int unsigned ACT_W     = 6;
  localparam int unsigned ACT_RESET = 32;

  // Request kinds; the two unused codes fall to the default arms
  typedef enum logic [2:0] {
    KIND_FIND  = 3'd0,
    KIND_PLACE = 3'd1,
    KIND_FIRST = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_READ  = 3'd4,
    KIND_WRITE = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_NONE  = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CLEAR,
    S_PLACE,
    S_FINISH
  } fsm_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_step;
    logic set_hit;
    logic clr_step;
    logic init_step;
    logic rd_idx;
    logic wr_idx;
    logic wr_place;
    logic load_out;
  } pst_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  idx_ok;
    logic  hit;
    logic  cmp_vld;
    logic  scan_done;
    logic  init_last;
    logic  out_free;
  } pst_sts_t;

endpackage

/* hw/rtl/pst_dp.sv */
module pst_dp
  import pst_pkg::*;
#(
  parameter int unsigned SLOTS   = 32,
  parameter int unsigned ID_BITS = 22
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pst_cmd_t                 cmd,
  output pst_sts_t                 sts,
  input  logic [2:0]               in_kind,
  input  logic [$clog2(SLOTS)-1:0] in_slot_index,
  input  logic [ID_BITS-1:0]       in_process_id,
  input  logic                     cfg_valid,
  input  logic [ACT_W-1:0]         cfg_data,
  output logic                     cfg_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [$clog2(SLOTS)-1:0] out_found_index,
  output logic [ID_BITS-1:0]       out_read_id,
  output logic [1:0]               out_status
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned LIM_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

  // Slot store, one port
  logic [ID_BITS-1:0] mem [SLOTS];
  logic [ID_BITS-1:0] rd_data_r;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_addr;
  logic [ID_BITS-1:0] mem_wd;

  // Configuration and request registers
  logic [ACT_W-1:0]   active_r;
  kind_t              kind_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ID_BITS-1:0] pid_r;

  // Scan state
  logic [CNT_W-1:0]   scan_addr_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_vld_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;

  // Result register
  logic               out_valid_r;
  logic [IDX_W-1:0]   found_r;
  logic [ID_BITS-1:0] rid_r;
  status_t            status_r;
  logic [IDX_W-1:0]   found_nxt;
  logic [ID_BITS-1:0] rid_nxt;
  status_t            status_nxt;

  logic [LIM_W-1:0]   act_ext;
  logic [LIM_W-1:0]   lim_w;
  logic [CNT_W-1:0]   live_n;
  logic               scan_done;
  logic               match;

  // Cap the active count at the table size
  assign act_ext = LIM_W'(active_r);
  assign lim_w   = (act_ext > LIM_W'(SLOTS)) ? LIM_W'(SLOTS) : act_ext;
  assign live_n  = CNT_W'(lim_w);

  assign scan_done = (scan_addr_r >= live_n);

  // Slot test for the search kinds
  always_comb begin
    case (kind_r)
      KIND_FIND:  match = (rd_data_r == pid_r);
      KIND_PLACE: match = (rd_data_r == '0);
      KIND_FIRST: match = (rd_data_r != '0);
      default:    match = 1'b0;
    endcase
  end

  assign sts.kind      = kind_r;
  assign sts.idx_ok    = (CNT_W'(idx_r) < live_n);
  assign sts.hit       = cmp_vld_r & match;
  assign sts.cmp_vld   = cmp_vld_r;
  assign sts.scan_done = scan_done;
  assign sts.init_last = (scan_addr_r == CNT_W'(SLOTS - 1));
  assign sts.out_free  = ~out_valid_r | out_ready;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_W'(ACT_RESET);
    end else if (cfg_valid) begin
      active_r <= cfg_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r <= kind_t'(in_kind);
      idx_r  <= in_slot_index;
      pid_r  <= in_process_id;
    end
  end

  // Memory port selection
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = scan_addr_r[IDX_W-1:0];
    mem_wd   = '0;
    if (cmd.init_step || (cmd.clr_step && !scan_done)) begin
      mem_we = 1'b1;
    end
    if (cmd.scan_step && !scan_done) begin
      mem_re = 1'b1;
    end
    if (cmd.rd_idx) begin
      mem_re   = 1'b1;
      mem_addr = idx_r;
    end
    if (cmd.wr_idx) begin
      mem_we   = 1'b1;
      mem_addr = idx_r;
      mem_wd   = pid_r;
    end
    if (cmd.wr_place) begin
      mem_we   = 1'b1;
      mem_addr = hit_idx_r;
      mem_wd   = pid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Advance the scan pointer and track the slot under test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_addr_r <= '0;
        cmp_vld_r   <= 1'b0;
        hit_r       <= 1'b0;
      end else begin
        if (cmd.init_step ||
            ((cmd.scan_step || cmd.clr_step) && !scan_done)) begin
          scan_addr_r <= scan_addr_r + 1'b1;
        end
        if (cmd.scan_step) begin
          cmp_vld_r <= ~scan_done;
        end
        if (cmd.set_hit) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx_r <= scan_addr_r[IDX_W-1:0];
    end
    if (cmd.set_hit) begin
      hit_idx_r <= cmp_idx_r;
    end
  end

  // Form the result
  always_comb begin
    found_nxt  = '0;
    rid_nxt    = '0;
    status_nxt = STS_OK;
    case (kind_r)
      KIND_FIND, KIND_FIRST: begin
        if (hit_r) found_nxt = hit_idx_r;
        else       status_nxt = STS_NONE;
      end
      KIND_PLACE: begin
        if (hit_r) found_nxt = hit_idx_r;
        else       status_nxt = STS_FULL;
      end
      KIND_CLEAR: begin
        status_nxt = STS_OK;
      end
      KIND_READ: begin
        if (sts.idx_ok) begin
          found_nxt = idx_r;
          rid_nxt   = rd_data_r;
        end else begin
          status_nxt = STS_RANGE;
        end
      end
      KIND_WRITE: begin
        if (sts.idx_ok) found_nxt = idx_r;
        else            status_nxt = STS_RANGE;
      end
      default: begin
        status_nxt = STS_RANGE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found_r  <= found_nxt;
      rid_r    <= rid_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = found_r;
  assign out_read_id     = rid_r;
  assign out_status      = status_r;

endmodule

/* hw/rtl/pst_ctrl.sv */
module pst_ctrl
  import pst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pst_sts_t sts,
  output pst_cmd_t cmd
);

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_FIND, KIND_PLACE, KIND_FIRST: state_nxt = S_SCAN;
          KIND_CLEAR:                        state_nxt = S_CLEAR;
          default:                           state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = (sts.kind == KIND_PLACE) ? S_PLACE : S_FINISH;
        end else if (!sts.cmp_vld && sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_CLEAR: begin
        if (sts.scan_done) state_nxt = S_FINISH;
      end
      S_PLACE: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_FIND, KIND_PLACE, KIND_FIRST, KIND_CLEAR: cmd.scan_start = 1'b1;
          KIND_READ:  cmd.rd_idx = sts.idx_ok;
          KIND_WRITE: cmd.wr_idx = sts.idx_ok;
          default: ;
        endcase
      end
      S_SCAN: begin
        if (sts.hit) cmd.set_hit   = 1'b1;
        else         cmd.scan_step = 1'b1;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_PLACE: begin
        cmd.wr_place = 1'b1;
      end
      S_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/process_slot_table_top.sv */
// Process slot table: a store of process ids, zero marking an empty slot.
// Input channel (in_valid/in_ready) carries one request item: kind, slot
// index and process id. Result channel (out_valid/out_ready) returns one
// item per request: found index, read id and status. The configuration
// channel (cfg_valid/cfg_ready/cfg_data) sets the number of active slots,
// L, and is always ready; write it only while no request is in flight.
// One request is handled at a time, all through a single-port slot memory
// that reads or writes one slot per cycle:
//   find, place, first occupied: one slot read per cycle, stopping at the
//     first match; place then writes the process id into the matched slot
//   clear: one slot zeroed per cycle, over the L active slots
//   read, write: the indexed slot is accessed only if it lies below L
// The next request is taken in the cycle after the result register loads.
// After reset the memory is zeroed by a pass over all SLOTS slots, during
// which in_ready stays low; active slots reset to 32.
// A result is held in an output register until taken; while the receiver
// stalls, the next request is accepted and worked, and it waits in its
// final state until the output register is free.
module process_slot_table_top
  import pst_pkg::*;
#(
  parameter int unsigned SLOTS   = 32,
  parameter int unsigned ID_BITS = 22
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_kind,
  input  logic [$clog2(SLOTS)-1:0] in_slot_index,
  input  logic [ID_BITS-1:0]       in_process_id,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ACT_W-1:0]         cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [$clog2(SLOTS)-1:0] out_found_index,
  output logic [ID_BITS-1:0]       out_read_id,
  output logic [1:0]               out_status
);

  pst_cmd_t cmd;
  pst_sts_t sts;

  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pst_dp #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_slot_index   (in_slot_index),
    .in_process_id   (in_process_id),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .cfg_ready       (cfg_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_index (out_found_index),
    .out_read_id     (out_read_id),
    .out_status      (out_status)
  );

endmodule
